[sv/shash_pkg.sv]
`timescale 1ns / 1ps

package shash_pkg;

    localparam int LenBitsDefault = 64;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        part_last;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } state_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[sv/shash_buf.sv]
`timescale 1ns / 1ps

// Block buffer: sixteen big-endian words, written one byte lane at a time,
// read one word per cycle with registered data.
module shash_buf (
    input  logic        aclk,
    input  logic        wr_en,
    input  logic [3:0]  wr_addr,
    input  logic [1:0]  wr_lane,
    input  logic [7:0]  wr_byte,
    input  logic [3:0]  rd_addr,
    output logic [31:0] rd_data
);

    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;
    logic [1:0]  lane_idx;

    assign lane_idx = 2'd3 - wr_lane;
    assign rd_data  = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr][{lane_idx, 3'b000} +: 8] <= wr_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

[sv/sha256_stream_hash.sv]
`timescale 1ns / 1ps

// SHA-256 over a byte stream. Each accepted request carries at most one
// message byte; bytes are taken at one per cycle until a 64-byte block is full.
// A full block then runs one load, 64 rounds through a single round unit fed
// from the block buffer memory and a 16-word schedule, and one final add, with
// s_ready low. A request with end_of_message pads the message in flight in one
// block pass, or two when more than 55 bytes sit in the last block, after which
// the digest leaves as four 64-bit big-endian parts, part 0 first, one per cycle
// as m_ready allows. The engine then starts over from the initial hash.
module sha256_stream_hash #(
    parameter int LENGTH_COUNTER_BITS = shash_pkg::LenBitsDefault
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  shash_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output shash_pkg::out_t  m_data
);

    localparam logic [63:0] LenMask = {64{1'b1}} >> (64 - LENGTH_COUNTER_BITS);

    shash_pkg::state_t state_reg, state_next;

    logic [31:0] hash_reg [8];
    logic [31:0] wk_reg [8];
    logic [31:0] sched_reg [16];
    logic [5:0]  fill_reg;
    logic [60:0] total_reg;
    logic [5:0]  round_reg;
    logic [63:0] len_reg;
    logic [6:0]  limit_reg;
    logic        pad_en_reg;
    logic        len_en_reg;
    logic        end_pend_reg;
    logic [1:0]  part_reg;

    logic        s_fire;
    logic        m_fire;
    logic        full_now;
    logic [6:0]  count_now;
    logic [60:0] len_sum;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    logic [31:0] blk_word;
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;

    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign full_now  = s_data.byte_present && (fill_reg == 6'd63);
    assign count_now = {1'b0, fill_reg} + {6'd0, s_data.byte_present};
    assign len_sum   = total_reg + {54'd0, count_now};

    assign rd_addr = (state_reg == shash_pkg::ST_ROUND) ? (round_reg[3:0] + 4'd1) : 4'd0;

    shash_buf u_buf (
        .aclk    (aclk),
        .wr_en   (s_fire && s_data.byte_present),
        .wr_addr (fill_reg[5:2]),
        .wr_lane (fill_reg[1:0]),
        .wr_byte (s_data.msg_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Padding is applied on the read side: bytes past the message become the
    // pad marker, zeros, and the bit length in the last eight bytes.
    always_comb begin
        logic [5:0] pos;
        logic [7:0] b;
        blk_word = '0;
        for (int j = 0; j < 4; j++) begin
            pos = {round_reg[3:0], 2'(j)};
            if ({1'b0, pos} < limit_reg) begin
                b = rd_data[31 - 8 * j -: 8];
            end else if (pad_en_reg && ({1'b0, pos} == limit_reg)) begin
                b = shash_pkg::PAD_BYTE;
            end else begin
                b = 8'h00;
            end
            if (len_en_reg && (pos >= 6'd56)) begin
                b = len_reg[{3'd7 - pos[2:0], 3'b000} +: 8];
            end
            blk_word[31 - 8 * j -: 8] = b;
        end
    end

    always_comb begin
        if (round_reg < 6'd16) begin
            w_cur = blk_word;
        end else begin
            w_cur = shash_pkg::sml_sig1(sched_reg[14]) + sched_reg[9]
                  + shash_pkg::sml_sig0(sched_reg[1]) + sched_reg[0];
        end
        t1 = wk_reg[7] + shash_pkg::big_sig1(wk_reg[4])
           + ((wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]))
           + shash_pkg::ROUND_K[round_reg] + w_cur;
        t2 = shash_pkg::big_sig0(wk_reg[0])
           + ((wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            shash_pkg::ST_IDLE: begin
                if (s_fire && (full_now || s_data.end_of_message)) begin
                    state_next = shash_pkg::ST_LOAD;
                end
            end
            shash_pkg::ST_LOAD: begin
                state_next = shash_pkg::ST_ROUND;
            end
            shash_pkg::ST_ROUND: begin
                if (round_reg == 6'd63) begin
                    state_next = shash_pkg::ST_FINISH;
                end
            end
            shash_pkg::ST_FINISH: begin
                if (len_en_reg) begin
                    state_next = shash_pkg::ST_OUT;
                end else if (pad_en_reg || end_pend_reg) begin
                    state_next = shash_pkg::ST_LOAD;
                end else begin
                    state_next = shash_pkg::ST_IDLE;
                end
            end
            shash_pkg::ST_OUT: begin
                if (m_fire && (part_reg == 2'd3)) begin
                    state_next = shash_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = shash_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            shash_pkg::ST_IDLE: s_ready = 1'b1;
            shash_pkg::ST_OUT:  m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign m_data.digest_part = {hash_reg[{part_reg, 1'b0}], hash_reg[{part_reg, 1'b1}]};
    assign m_data.part_index  = part_reg;
    assign m_data.part_last   = (part_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= shash_pkg::ST_IDLE;
            fill_reg     <= '0;
            total_reg    <= '0;
            round_reg    <= '0;
            part_reg     <= '0;
            limit_reg    <= '0;
            pad_en_reg   <= 1'b0;
            len_en_reg   <= 1'b0;
            end_pend_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= shash_pkg::INIT_HASH[i];
                wk_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                shash_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.end_of_message) begin
                            len_reg <= {len_sum, 3'b000} & LenMask;
                        end
                        if (full_now) begin
                            fill_reg     <= '0;
                            total_reg    <= s_data.end_of_message ? 61'd0 : total_reg + 61'd64;
                            limit_reg    <= 7'd64;
                            pad_en_reg   <= 1'b0;
                            len_en_reg   <= 1'b0;
                            end_pend_reg <= s_data.end_of_message;
                        end else if (s_data.end_of_message) begin
                            fill_reg     <= '0;
                            total_reg    <= '0;
                            limit_reg    <= count_now;
                            pad_en_reg   <= 1'b1;
                            len_en_reg   <= (count_now <= 7'd55);
                            end_pend_reg <= 1'b0;
                        end else if (s_data.byte_present) begin
                            fill_reg <= fill_reg + 6'd1;
                        end
                    end
                end
                shash_pkg::ST_LOAD: begin
                    round_reg <= '0;
                    for (int i = 0; i < 8; i++) begin
                        wk_reg[i] <= hash_reg[i];
                    end
                end
                shash_pkg::ST_ROUND: begin
                    round_reg <= round_reg + 6'd1;
                    wk_reg[7] <= wk_reg[6];
                    wk_reg[6] <= wk_reg[5];
                    wk_reg[5] <= wk_reg[4];
                    wk_reg[4] <= wk_reg[3] + t1;
                    wk_reg[3] <= wk_reg[2];
                    wk_reg[2] <= wk_reg[1];
                    wk_reg[1] <= wk_reg[0];
                    wk_reg[0] <= t1 + t2;
                end
                shash_pkg::ST_FINISH: begin
                    round_reg <= '0;
                    part_reg  <= '0;
                    for (int i = 0; i < 8; i++) begin
                        hash_reg[i] <= hash_reg[i] + wk_reg[i];
                    end
                    if (!len_en_reg) begin
                        if (pad_en_reg) begin
                            // Pad marker went into the previous block; this one
                            // holds only zeros and the length.
                            limit_reg  <= 7'd0;
                            pad_en_reg <= 1'b0;
                            len_en_reg <= 1'b1;
                        end else if (end_pend_reg) begin
                            limit_reg    <= 7'd0;
                            pad_en_reg   <= 1'b1;
                            len_en_reg   <= 1'b1;
                            end_pend_reg <= 1'b0;
                        end
                    end
                end
                shash_pkg::ST_OUT: begin
                    if (m_fire) begin
                        part_reg <= part_reg + 2'd1;
                        if (part_reg == 2'd3) begin
                            for (int i = 0; i < 8; i++) begin
                                hash_reg[i] <= shash_pkg::INIT_HASH[i];
                            end
                        end
                    end
                end
                default: begin
                    round_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == shash_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= w_cur;
        end
    end

endmodule
